>>> src/pqt_pkg.sv
// ============================================================================
// pqt_pkg
// Shared types and constants for the max priority queue table.
// ============================================================================
package pqt_pkg;

    localparam int CAPACITY = 64;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        REQ_ADD     = 2'd0,
        REQ_SEARCH  = 2'd1,
        REQ_CHANGE  = 2'd2,
        REQ_EXTRACT = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0]        id;
        logic signed [31:0] prio;
    } entry_t;

    typedef struct packed {
        logic            we;
        logic [AW-1:0]   waddr;
        entry_t          wdata;
        logic            re;
        logic [AW-1:0]   raddr;
    } mem_req_t;

    typedef struct packed {
        status_t            status;
        logic [15:0]        id;
        logic signed [31:0] prio;
    } result_t;

endpackage

>>> src/max_priority_queue_table_top.sv
// ============================================================================
// max_priority_queue_table_top
// Max priority queue over an unsorted table of (id, priority) entries.
// ============================================================================
// Usage:
// - input channel in_valid/in_ready carries one request beat: req_type,
//   entry_id, priority_in; output channel out_valid/out_ready carries one
//   result beat per request: status, result_id, result_priority
// - one request at a time; in_ready is high only while the sequencer idles
// - add writes its entry when the request is taken and needs no table scan
// - search and change read one table slot per cycle through the single read
//   port of the entry store, newest first
// - extract reads all entries once to find the maximum, then moves each later
//   entry down one slot
// - reset empties the table at once; the store contents are not cleared,
//   only the entry count
// - a result waits in the output register while out_ready is low; the
//   sequencer holds a finished result until that register frees up, so the
//   next request can be taken while the previous beat is still waiting
// ============================================================================
module max_priority_queue_table_top
    import pqt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [15:0]        entry_id,
    input  logic signed [31:0] priority_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [15:0]        result_id,
    output logic signed [31:0] result_priority
);

    mem_req_t mem_req;
    entry_t   rdata;
    result_t  res;
    logic     res_valid;
    logic     out_free;

    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [15:0]        result_id_reg;
    logic signed [31:0] result_priority_reg;

    assign out_free = !out_valid_reg || out_ready;

    pqt_mem u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    pqt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .entry_id    (entry_id),
        .priority_in (priority_in),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .mem_req     (mem_req),
        .rdata       (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            status_reg          <= res.status;
            result_id_reg       <= res.id;
            result_priority_reg <= res.prio;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign result_id       = result_id_reg;
    assign result_priority = result_priority_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while sequencer busy");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> out_valid)
        else $error("finished result not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("result overwrites a waiting beat");

    a_empty_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> result_id == 16'd0 && result_priority == 32'sd0)
        else $error("empty status with nonzero payload");
`endif

endmodule

>>> src/pqt_mem.sv
// ============================================================================
// pqt_mem
// Entry store: one write port, one read port with registered read data.
// ============================================================================
module pqt_mem
    import pqt_pkg::*;
(
    input  logic     clk,
    input  mem_req_t mem_req,
    output entry_t   rdata
);

    entry_t entry_mem [CAPACITY];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            entry_mem[mem_req.waddr] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rdata_reg <= entry_mem[mem_req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/pqt_ctrl.sv
// ============================================================================
// pqt_ctrl
// Request sequencer: writes an add straight into the store, scans the entry
// store one slot per cycle for the other requests and compacts it after an extract.
// ============================================================================
module pqt_ctrl
    import pqt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [15:0]        entry_id,
    input  logic signed [31:0] priority_in,
    input  logic               out_free,
    output logic               res_valid,
    output result_t            res,
    output mem_req_t           mem_req,
    input  entry_t             rdata
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    req_t               kind_reg, kind_next;
    logic [15:0]        id_reg, id_next;
    logic signed [31:0] prio_reg, prio_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic               issue_reg, issue_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pidx_reg, pidx_next;
    logic [AW-1:0]      best_idx_reg, best_idx_next;
    entry_t             best_reg, best_next;
    result_t            res_reg, res_next;
    logic [AW-1:0]      last_up;

    assign last_up = AW'(count_reg - CW'(1));

    always_comb
    begin
        logic          sel;
        entry_t        fin_best;
        logic [AW-1:0] fin_idx;

        state_next    = state_reg;
        kind_next     = kind_reg;
        id_next       = id_reg;
        prio_next     = prio_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        issue_next    = issue_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        res_next      = res_reg;
        mem_req       = '0;
        res_valid     = 1'b0;
        in_ready      = (state_reg == S_IDLE);
        sel           = 1'b0;
        fin_best      = best_reg;
        fin_idx       = best_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = req_t'(req_type);
                    id_next    = entry_id;
                    prio_next  = priority_in;
                    issue_next = 1'b1;
                    pend_next  = 1'b0;
                    case (req_t'(req_type))
                        REQ_ADD:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                res_next = '{status: ST_FULL, id: entry_id, prio: '0};
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = AW'(count_reg);
                                mem_req.wdata = '{id: entry_id, prio: priority_in};
                                count_next    = count_reg + CW'(1);
                                res_next      = '{status: ST_OK, id: entry_id, prio: '0};
                            end
                            state_next = S_DONE;
                        end
                        REQ_SEARCH, REQ_CHANGE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next   = '{status: ST_NOT_FOUND, id: entry_id, prio: '1};
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ptr_next   = last_up;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next   = '{status: ST_EMPTY, id: '0, prio: '0};
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                mem_req.re    = issue_reg;
                mem_req.raddr = ptr_reg;
                pend_next     = issue_reg;
                pidx_next     = ptr_reg;
                if (issue_reg)
                begin
                    if (kind_reg == REQ_EXTRACT)
                    begin
                        if (ptr_reg == last_up)
                            issue_next = 1'b0;
                        else
                            ptr_next = ptr_reg + AW'(1);
                    end
                    else
                    begin
                        if (ptr_reg == '0)
                            issue_next = 1'b0;
                        else
                            ptr_next = ptr_reg - AW'(1);
                    end
                end
                if (pend_reg)
                begin
                    if (kind_reg == REQ_EXTRACT)
                    begin
                        // newest wins on ties, so greater-or-equal takes over
                        sel = (pidx_reg == '0) ||
                              ($signed(rdata.prio) >= $signed(best_reg.prio));
                        fin_best = sel ? rdata : best_reg;
                        fin_idx  = sel ? pidx_reg : best_idx_reg;
                        best_next     = fin_best;
                        best_idx_next = fin_idx;
                        if (pidx_reg == last_up)
                        begin
                            res_next   = '{status: ST_OK, id: fin_best.id, prio: fin_best.prio};
                            issue_next = 1'b0;
                            pend_next  = 1'b0;
                            if (fin_idx == last_up)
                            begin
                                count_next = count_reg - CW'(1);
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ptr_next   = fin_idx + AW'(1);
                                issue_next = 1'b1;
                                state_next = S_SHIFT;
                            end
                        end
                    end
                    else
                    begin
                        if (rdata.id == id_reg)
                        begin
                            if (kind_reg == REQ_CHANGE)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = pidx_reg;
                                mem_req.wdata = '{id: id_reg, prio: prio_reg};
                                res_next      = '{status: ST_OK, id: id_reg, prio: prio_reg};
                            end
                            else
                            begin
                                res_next = '{status: ST_OK, id: id_reg, prio: rdata.prio};
                            end
                            issue_next = 1'b0;
                            pend_next  = 1'b0;
                            state_next = S_DONE;
                        end
                        else if (pidx_reg == '0)
                        begin
                            res_next   = '{status: ST_NOT_FOUND, id: id_reg, prio: '1};
                            issue_next = 1'b0;
                            pend_next  = 1'b0;
                            state_next = S_DONE;
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                mem_req.re    = issue_reg;
                mem_req.raddr = ptr_reg;
                pend_next     = issue_reg;
                pidx_next     = ptr_reg;
                if (issue_reg)
                begin
                    if (ptr_reg == last_up)
                        issue_next = 1'b0;
                    else
                        ptr_next = ptr_reg + AW'(1);
                end
                if (pend_reg)
                begin
                    // move each later entry down one slot
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pidx_reg - AW'(1);
                    mem_req.wdata = rdata;
                    if (pidx_reg == last_up)
                    begin
                        count_next = count_reg - CW'(1);
                        issue_next = 1'b0;
                        pend_next  = 1'b0;
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            issue_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        id_reg       <= id_next;
        prio_reg     <= prio_next;
        ptr_reg      <= ptr_next;
        pidx_reg     <= pidx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        res_reg      <= res_next;
    end

    assign res = res_reg;

endmodule
